FILE: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int ELEM_W        = 16;

  typedef logic signed [ELEM_W-1:0] rmq_elem_t;

  // which component leads the solution
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } rmq_branch_t;

endpackage

`default_nettype wire

FILE: rtl/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_if
// Valid/ready channels of the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_in_if;
  import rmq_pkg::*;
  logic      valid;
  logic      ready;
  rmq_elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic        valid;
  logic        ready;
  rmq_elem_t   qx, qy, qz, qw;
  rmq_branch_t branch;
  logic        degenerate;

  modport source (output valid, qx, qy, qz, qw, branch, degenerate, input ready);
  modport sink   (input valid, qx, qy, qz, qw, branch, degenerate, output ready);
endinterface

`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix to unit quaternion by the trace method, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   m00 .. m22, signed, FRAC_BITS fraction bits
//  out_ch   out  valid/ready   qx qy qz qw, branch, degenerate
//
//  one item enters per cycle unless the output stalls; items pass stage 1,
//  the bit-per-stage square root (SW stages), stage 2, dividers (NW stages), output reg
//  rst_n clears every valid bit; data registers are not reset
//  a full output register not taken holds the whole pipeline, nothing lost
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rmq_in_if.sink     in_ch,
  rmq_out_if.source  out_ch
);
  import rmq_pkg::*;

  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int RW    = (FRAC_BITS > 17) ? FRAC_BITS + 2 : 19;
  localparam int SW    = (RW + FRAC_BITS + 3) / 2;
  localparam int VW    = 2 * SW;
  localparam int NW    = FRAC_BITS + 18;
  localparam int HI_Q  = (ONE_Q < 32767) ? ONE_Q : 32767;
  localparam int LO_M  = (ONE_Q < 32768) ? ONE_Q : 32768;
  localparam int DW    = ELEM_W + 1;
  localparam int SB1   = 2 + 3 * DW;
  localparam int SB2   = 2 + 3 + SW;

  logic adv;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 1: branch, radicand, off-diagonal terms
  logic signed [ELEM_W+1:0] trace;
  logic signed [RW:0]       rad;
  rmq_branch_t              br_nxt;
  logic signed [DW-1:0]     d_nxt [3];

  logic                     s1_vld_r;
  rmq_branch_t              s1_br_r;
  logic [RW-1:0]            s1_rad_r;
  logic signed [DW-1:0]     s1_d_r [3];

  always_comb begin
    trace = (ELEM_W+2)'(in_ch.m00) + (ELEM_W+2)'(in_ch.m11) + (ELEM_W+2)'(in_ch.m22);
    if (trace > 0) begin
      br_nxt   = BR_TRACE;
      rad      = (RW+1)'(ONE_Q) + (RW+1)'(in_ch.m00) + (RW+1)'(in_ch.m11)
               + (RW+1)'(in_ch.m22);
      d_nxt[0] = DW'(in_ch.m21) - DW'(in_ch.m12);
      d_nxt[1] = DW'(in_ch.m02) - DW'(in_ch.m20);
      d_nxt[2] = DW'(in_ch.m10) - DW'(in_ch.m01);
    end else if (in_ch.m00 > in_ch.m11 && in_ch.m00 > in_ch.m22) begin
      br_nxt   = BR_X;
      rad      = (RW+1)'(ONE_Q) + (RW+1)'(in_ch.m00) - (RW+1)'(in_ch.m11)
               - (RW+1)'(in_ch.m22);
      d_nxt[0] = DW'(in_ch.m21) - DW'(in_ch.m12);
      d_nxt[1] = DW'(in_ch.m01) + DW'(in_ch.m10);
      d_nxt[2] = DW'(in_ch.m02) + DW'(in_ch.m20);
    end else if (in_ch.m11 > in_ch.m22) begin
      br_nxt   = BR_Y;
      rad      = (RW+1)'(ONE_Q) + (RW+1)'(in_ch.m11) - (RW+1)'(in_ch.m00)
               - (RW+1)'(in_ch.m22);
      d_nxt[0] = DW'(in_ch.m02) - DW'(in_ch.m20);
      d_nxt[1] = DW'(in_ch.m01) + DW'(in_ch.m10);
      d_nxt[2] = DW'(in_ch.m12) + DW'(in_ch.m21);
    end else begin
      br_nxt   = BR_Z;
      rad      = (RW+1)'(ONE_Q) + (RW+1)'(in_ch.m22) - (RW+1)'(in_ch.m00)
               - (RW+1)'(in_ch.m11);
      d_nxt[0] = DW'(in_ch.m10) - DW'(in_ch.m01);
      d_nxt[1] = DW'(in_ch.m02) + DW'(in_ch.m20);
      d_nxt[2] = DW'(in_ch.m12) + DW'(in_ch.m21);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_br_r  <= br_nxt;
      s1_rad_r <= rad[RW] ? '0 : rad[RW-1:0];   // negative radicand clamps to zero
      s1_d_r   <= d_nxt;
    end
  end

  // ---------------- square root: s = floor(sqrt(r << (FRAC_BITS+2)))
  logic [VW-1:0]  sq_v;
  logic           sq_vld;
  logic [SW-1:0]  sq_s;
  logic [SB1-1:0] sq_sb;

  assign sq_v = VW'({s1_rad_r, {(FRAC_BITS+2){1'b0}}});

  rmq_sqrt_pipe #(
    .SW  (SW),
    .SBW (SB1)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s1_vld_r),
    .in_v      (sq_v),
    .in_sb     ({s1_br_r, s1_d_r[0], s1_d_r[1], s1_d_r[2]}),
    .out_valid (sq_vld),
    .out_s     (sq_s),
    .out_sb    (sq_sb)
  );

  // ---------------- stage 2: rounded numerators |d| * ONE + s/2
  logic signed [DW-1:0] sq_d [3];
  logic [DW-1:0]        d_mag [3];
  logic [NW-1:0]        num_nxt [3];

  logic                 s2_vld_r;
  logic [NW-1:0]        s2_num_r [3];
  logic [SW-1:0]        s2_s_r;
  logic [1:0]           s2_br_r;
  logic [2:0]           s2_neg_r;

  assign sq_d[0] = sq_sb[3*DW-1 -: DW];
  assign sq_d[1] = sq_sb[2*DW-1 -: DW];
  assign sq_d[2] = sq_sb[DW-1:0];

  for (genvar l = 0; l < 3; l++) begin : g_num
    assign d_mag[l]   = sq_d[l][DW-1] ? DW'(-sq_d[l]) : DW'(sq_d[l]);
    assign num_nxt[l] = (NW'(d_mag[l]) << FRAC_BITS) + NW'(sq_s >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_num_r <= num_nxt;
      s2_s_r   <= sq_s;
      s2_br_r  <= sq_sb[SB1-1 -: 2];
      s2_neg_r <= {sq_d[0][DW-1], sq_d[1][DW-1], sq_d[2][DW-1]};
    end
  end

  // ---------------- dividers
  logic           dv_vld;
  logic [NW-1:0]  dv_quo [3];
  logic [SB2-1:0] dv_sb;

  rmq_div_pipe #(
    .NW  (NW),
    .SW  (SW),
    .SBW (SB2)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s2_vld_r),
    .in_num    (s2_num_r),
    .in_den    (s2_s_r),
    .in_sb     ({s2_br_r, s2_neg_r, s2_s_r}),
    .out_valid (dv_vld),
    .out_quo   (dv_quo),
    .out_sb    (dv_sb)
  );

  // ---------------- output stage: sign, saturation, component order, degenerate zeroing
  function automatic rmq_elem_t sat_q(input logic neg, input logic [NW-1:0] mag);
    rmq_elem_t res;
    if (neg) begin
      res = (mag > NW'(LO_M)) ? ELEM_W'(-LO_M) : ELEM_W'(-mag);
    end else begin
      res = (mag > NW'(HI_Q)) ? ELEM_W'(HI_Q) : ELEM_W'(mag);
    end
    return res;
  endfunction

  logic [SW-1:0]  dv_s;
  logic [2:0]     dv_neg;
  rmq_branch_t    dv_br;
  logic [SW:0]    lead_sum;
  rmq_elem_t      lead;
  rmq_elem_t      c [3];
  logic           degen;
  rmq_elem_t      qx_nxt, qy_nxt, qz_nxt, qw_nxt;

  logic           out_vld_r;
  rmq_elem_t      qx_r, qy_r, qz_r, qw_r;
  rmq_branch_t    br_r;
  logic           degen_r;

  assign dv_s     = dv_sb[SW-1:0];
  assign dv_neg   = dv_sb[SW+2:SW];
  assign dv_br    = rmq_branch_t'(dv_sb[SB2-1 -: 2]);
  assign lead_sum = ({1'b0, dv_s} + (SW+1)'(2)) >> 2;
  assign lead     = sat_q(1'b0, NW'(lead_sum));
  assign c[0]     = sat_q(dv_neg[2], dv_quo[0]);
  assign c[1]     = sat_q(dv_neg[1], dv_quo[1]);
  assign c[2]     = sat_q(dv_neg[0], dv_quo[2]);
  assign degen    = (dv_s == '0);

  always_comb begin
    case (dv_br)
      BR_TRACE: begin
        qx_nxt = c[0]; qy_nxt = c[1]; qz_nxt = c[2]; qw_nxt = lead;
      end
      BR_X: begin
        qx_nxt = lead; qy_nxt = c[1]; qz_nxt = c[2]; qw_nxt = c[0];
      end
      BR_Y: begin
        qx_nxt = c[1]; qy_nxt = lead; qz_nxt = c[2]; qw_nxt = c[0];
      end
      default: begin
        qx_nxt = c[1]; qy_nxt = c[2]; qz_nxt = lead; qw_nxt = c[0];
      end
    endcase
    if (degen) begin
      qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
      qz_r    <= qz_nxt;
      qw_r    <= qw_nxt;
      br_r    <= dv_br;
      degen_r <= degen;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.qx         = qx_r;
  assign out_ch.qy         = qy_r;
  assign out_ch.qz         = qz_r;
  assign out_ch.qw         = qw_r;
  assign out_ch.branch     = br_r;
  assign out_ch.degenerate = degen_r;

`ifndef SYNTH
  // a zero divisor forces every component to zero
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && degen_r |-> qx_r == '0 && qy_r == '0 && qz_r == '0 && qw_r == '0)
    else $error("degenerate item with nonzero components");

  // with a positive trace w leads and is strictly positive
  a_trace_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !degen_r && br_r == BR_TRACE |-> qw_r > 0)
    else $error("trace branch with non-positive w");

  // a stall freezes the pipeline front
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_vld_r) && $stable(s2_vld_r))
    else $error("pipeline moved while stalled");

  // a result held in the output register is not replaced while not taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> $stable(qw_r) && $stable(br_r) && $stable(degen_r))
    else $error("output changed while stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/rmq_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// Integer square root, one result bit per pipeline stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt_pipe #(
  parameter int SW  = 18,
  parameter int SBW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*SW-1:0]   in_v,
  input  wire logic [SBW-1:0]    in_sb,
  output logic                   out_valid,
  output logic [SW-1:0]          out_s,
  output logic [SBW-1:0]         out_sb
);

  localparam int VW = 2 * SW;

  logic            st_vld  [SW+1];
  logic [SW:0]     st_rem  [SW+1];
  logic [SW-1:0]   st_root [SW+1];
  logic [VW-1:0]   st_v    [SW+1];
  logic [SBW-1:0]  st_sb   [SW+1];

  assign st_vld[0]  = in_valid;
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_v[0]    = in_v;
  assign st_sb[0]   = in_sb;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [SW+2:0] rem_sh;
    logic [SW+2:0] trial;
    logic [SW+2:0] diff;
    logic          ge;

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {st_rem[k], st_v[k][VW-1 -: 2]};
    assign trial  = {1'b0, st_root[k], 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld[k+1] <= 1'b0;
      end else if (en) begin
        st_vld[k+1] <= st_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k+1]  <= ge ? diff[SW:0] : rem_sh[SW:0];
        st_root[k+1] <= {st_root[k][SW-2:0], ge};
        st_v[k+1]    <= {st_v[k][VW-3:0], 2'b00};
        st_sb[k+1]   <= st_sb[k];
      end
    end
  end

  assign out_valid = st_vld[SW];
  assign out_s     = st_root[SW];
  assign out_sb    = st_sb[SW];

endmodule

`default_nettype wire

FILE: rtl/rmq_div_pipe.sv
// ----------------------------------------------------------------------------
// rmq_div_pipe
// Three restoring dividers sharing one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_pipe #(
  parameter int NW  = 32,
  parameter int SW  = 18,
  parameter int SBW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NW-1:0]    in_num [3],
  input  wire logic [SW-1:0]    in_den,
  input  wire logic [SBW-1:0]   in_sb,
  output logic                  out_valid,
  output logic [NW-1:0]         out_quo [3],
  output logic [SBW-1:0]        out_sb
);

  logic            st_vld [NW+1];
  logic [NW-1:0]   st_qn  [NW+1][3];
  logic [SW-1:0]   st_rem [NW+1][3];
  logic [SW-1:0]   st_den [NW+1];
  logic [SBW-1:0]  st_sb  [NW+1];

  assign st_vld[0] = in_valid;
  assign st_den[0] = in_den;
  assign st_sb[0]  = in_sb;

  for (genvar l = 0; l < 3; l++) begin : g_in
    assign st_qn[0][l]  = in_num[l];
    assign st_rem[0][l] = '0;
    assign out_quo[l]   = st_qn[NW][l];
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld[k+1] <= 1'b0;
      end else if (en) begin
        st_vld[k+1] <= st_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_den[k+1] <= st_den[k];
        st_sb[k+1]  <= st_sb[k];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [SW:0] rem_sh;
      logic [SW:0] diff;
      logic        ge;

      // numerator bits shift out the top while quotient bits shift in below
      assign rem_sh = {st_rem[k][l], st_qn[k][l][NW-1]};
      assign diff   = rem_sh - {1'b0, st_den[k]};
      assign ge     = (rem_sh >= {1'b0, st_den[k]});

      always_ff @(posedge clk) begin
        if (en) begin
          st_rem[k+1][l] <= ge ? diff[SW-1:0] : rem_sh[SW-1:0];
          st_qn[k+1][l]  <= {st_qn[k][l][NW-2:0], ge};
        end
      end
    end
  end

  assign out_valid = st_vld[NW];
  assign out_sb    = st_sb[NW];

endmodule

`default_nettype wire

FILE: tb/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Watches both channels of the quaternion unit, predicts each result from the
// accepted matrix and compares it field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmq_checker #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rmq_in_if         in_mon,
  rmq_out_if        out_mon,
  output int        fail_count,
  output int        pending
);
  import rmq_pkg::*;

  typedef struct packed {
    rmq_elem_t   qx, qy, qz, qw;
    rmq_branch_t branch;
    logic        degenerate;
  } quat_t;

  quat_t expected_quats[$];

  localparam longint ONE = longint'(1) << FRAC_BITS;

  function automatic longint isqrt(longint v);
    longint root, bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // nearest, ties away from zero
  function automatic longint div_near(longint d, longint s);
    longint num, mag;
    num = d * ONE;
    mag = num < 0 ? -num : num;
    mag = (mag + (s >> 1)) / s;
    return num < 0 ? -mag : mag;
  endfunction

  function automatic rmq_elem_t clip(longint v);
    longint hi, lo;
    hi = ONE < 32767 ? ONE : 32767;
    lo = -ONE > -32768 ? -ONE : -32768;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return rmq_elem_t'(v);
  endfunction

  function automatic quat_t solve_quat(longint a00, longint a01, longint a02,
                                       longint a10, longint a11, longint a12,
                                       longint a20, longint a21, longint a22);
    longint rad, s, c[4], d0, d1, d2;
    rmq_branch_t br;
    quat_t res;
    c = '{0, 0, 0, 0};
    if (a00 + a11 + a22 > 0) begin
      br = BR_TRACE; rad = ONE + a00 + a11 + a22;
      d0 = a21 - a12; d1 = a02 - a20; d2 = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      br = BR_X; rad = ONE + a00 - a11 - a22;
      d0 = a21 - a12; d1 = a01 + a10; d2 = a02 + a20;
    end else if (a11 > a22) begin
      br = BR_Y; rad = ONE + a11 - a00 - a22;
      d0 = a02 - a20; d1 = a01 + a10; d2 = a12 + a21;
    end else begin
      br = BR_Z; rad = ONE + a22 - a00 - a11;
      d0 = a10 - a01; d1 = a02 + a20; d2 = a12 + a21;
    end
    if (rad < 0) rad = 0;
    s = isqrt(rad << (FRAC_BITS + 2));
    if (s != 0) begin
      // c holds x, y, z, w
      case (br)
        BR_TRACE: begin
          c[3] = (s + 2) >> 2; c[0] = div_near(d0, s);
          c[1] = div_near(d1, s); c[2] = div_near(d2, s);
        end
        BR_X: begin
          c[0] = (s + 2) >> 2; c[3] = div_near(d0, s);
          c[1] = div_near(d1, s); c[2] = div_near(d2, s);
        end
        BR_Y: begin
          c[1] = (s + 2) >> 2; c[3] = div_near(d0, s);
          c[0] = div_near(d1, s); c[2] = div_near(d2, s);
        end
        default: begin
          c[2] = (s + 2) >> 2; c[3] = div_near(d0, s);
          c[0] = div_near(d1, s); c[1] = div_near(d2, s);
        end
      endcase
    end
    res.qx = clip(c[0]); res.qy = clip(c[1]);
    res.qz = clip(c[2]); res.qw = clip(c[3]);
    res.branch = br;
    res.degenerate = (s == 0);
    return res;
  endfunction

  assign pending = expected_quats.size();

  always @(posedge clk) begin
    quat_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_quats.push_back(solve_quat(in_mon.m00, in_mon.m01, in_mon.m02,
                                            in_mon.m10, in_mon.m11, in_mon.m12,
                                            in_mon.m20, in_mon.m21, in_mon.m22));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.qx, out_mon.qy, out_mon.qz, out_mon.qw,
                out_mon.branch, out_mon.degenerate};
        if (expected_quats.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_quats.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives matrices into the quaternion unit under random stalls on both sides, except in
// the last random phase; directed corner cases first, then random rotations and noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import rmq_pkg::*;

  localparam int ONE_Q = 1 << FRAC_BITS_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   in_idle_pct = 38, out_idle_pct = 75;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  rmq_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11,
     in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    out_ch.ready = 1'b0;
  end

  // receiver stalls
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);

  function automatic rmq_elem_t rand_elem();
    case ($urandom_range(7))
      0: return rmq_elem_t'($urandom());
      1: return ($urandom_range(1)) ? rmq_elem_t'(ONE_Q) : rmq_elem_t'(-ONE_Q);
      default: return rmq_elem_t'(int'($urandom_range(2 * ONE_Q)) - ONE_Q);
    endcase
  endfunction

  // send one matrix, hold valid until taken; valid drops only while idling
  task automatic send_matrix(input rmq_elem_t e[9]);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11,
     in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} <=
      {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // rotation about one axis, built from a cosine c and a sine sn
  task automatic send_axis_rot(input int axis, input int c, input int sn);
    rmq_elem_t e[9];
    foreach (e[i]) e[i] = '0;
    e[axis * 4] = rmq_elem_t'(ONE_Q);
    case (axis)
      0: begin
        e[4] = rmq_elem_t'(c); e[8] = rmq_elem_t'(c);
        e[5] = rmq_elem_t'(-sn); e[7] = rmq_elem_t'(sn);
      end
      1: begin
        e[0] = rmq_elem_t'(c); e[8] = rmq_elem_t'(c);
        e[2] = rmq_elem_t'(sn); e[6] = rmq_elem_t'(-sn);
      end
      default: begin
        e[0] = rmq_elem_t'(c); e[4] = rmq_elem_t'(c);
        e[1] = rmq_elem_t'(-sn); e[3] = rmq_elem_t'(sn);
      end
    endcase
    send_matrix(e);
  endtask

  initial begin
    rmq_elem_t e[9];
    int ang;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, zeros, extremes, half-turns
    e = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q}; send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
    foreach (e[i]) e[i] = rmq_elem_t'(-ONE_Q); send_matrix(e);
    foreach (e[i]) e[i] = rmq_elem_t'(ONE_Q); send_matrix(e);
    foreach (e[i]) e[i] = 16'sh7fff; send_matrix(e);
    foreach (e[i]) e[i] = 16'sh8000; send_matrix(e);
    e = '{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q}; send_matrix(e);
    e = '{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q}; send_matrix(e);
    e = '{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q}; send_matrix(e);
    // mixed-sign and extreme diagonals
    e = '{-ONE_Q, 5, 5, 5, ONE_Q, 5, 5, 5, -ONE_Q}; send_matrix(e);
    e = '{-ONE_Q, 0, 0, 0, 0, 0, 0, 0, ONE_Q}; send_matrix(e);
    e = '{16'sh8000, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff}; send_matrix(e);
    // ties on the diagonal
    e = '{-100, 3, -7, 9, -100, 11, -13, 2, -100}; send_matrix(e);
    e = '{-50, 1, 2, 3, 40, 4, 5, 6, 40}; send_matrix(e);
    // trace just positive and just zero
    e = '{1, 100, 200, 300, 0, 400, 500, 600, 0}; send_matrix(e);
    e = '{-1, 100, 200, 300, 1, 400, 500, 600, 0}; send_matrix(e);
    // big off-diagonals for saturation
    e = '{-ONE_Q, 16'sh7fff, 16'sh8000, 16'sh8000, -ONE_Q, 16'sh7fff,
          16'sh7fff, 16'sh8000, -ONE_Q + 1};
    send_matrix(e);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin in_idle_pct = 75; out_idle_pct = 38; end
      if (phase == 2) begin in_idle_pct = 0; out_idle_pct = 0; end
      for (int n = 0; n < 480; n++) begin
        if ($urandom_range(9) < 6) begin
          ang = $urandom_range(359);
          send_axis_rot($urandom_range(2),
                        $rtoi($cos(ang * 3.14159265 / 180.0) * ONE_Q),
                        $rtoi($sin(ang * 3.14159265 / 180.0) * ONE_Q));
        end else begin
          foreach (e[i]) e[i] = rand_elem();
          send_matrix(e);
        end
      end
    end
    in_ch.valid <= 1'b0;

    out_idle_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rmq_sqrt_pipe.sv
rtl/rmq_div_pipe.sv
rtl/rotation_matrix_to_quaternion_unit.sv
tb/rmq_checker.sv
tb/testbench.sv
